// ----- rtl/nrm_pkg.sv -----
// nrm_pkg: shared types and constants of the regex thread matcher
// no dependencies; used by the interfaces and every module of the matcher
package nrm_pkg;

    localparam int ProgDepth = 64;
    localparam int AddrW     = $clog2(ProgDepth);
    localparam int CntW      = $clog2(ProgDepth + 1);
    localparam int ChrW      = 8;
    localparam int StatW     = 3;

    typedef enum logic [2:0] {
        OP_CHAR  = 3'd0,
        OP_RANGE = 3'd1,
        OP_ANY   = 3'd2,
        OP_MATCH = 3'd3,
        OP_JUMP  = 3'd4,
        OP_SPLIT = 3'd5,
        OP_SAVE  = 3'd6,
        OP_DEAD  = 3'd7
    } t_opcode;

    localparam logic [StatW-1:0] ST_PENDING = 3'd0;
    localparam logic [StatW-1:0] ST_MATCHED = 3'd1;
    localparam logic [StatW-1:0] ST_NOMATCH = 3'd2;
    localparam logic [StatW-1:0] ST_SKIPPED = 3'd3;
    localparam logic [StatW-1:0] ST_LOADED  = 3'd4;

    typedef struct packed {
        t_opcode           op;
        logic [ChrW-1:0]   chr;
        logic [ChrW-1:0]   lo;
        logic [ChrW-1:0]   hi;
        logic [AddrW-1:0]  next_a;
        logic [AddrW-1:0]  next_b;
    } t_instr;

    // item class decided at the front
    typedef enum logic [1:0] {
        K_LOAD = 2'd0,
        K_CHAR = 2'd1,
        K_END  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [ChrW-1:0]  chr;
        logic [AddrW-1:0] idx;
        t_instr           instr;
    } t_qitem;

endpackage

// ----- rtl/nrm_ifs.sv -----
// nrm_ifs: valid/ready channel interfaces of the regex thread matcher
// depends on nrm_pkg
interface nrm_in_if import nrm_pkg::*;;
    logic             valid;
    logic             ready;
    logic             mode;
    logic [ChrW-1:0]  text_char;
    logic [AddrW-1:0] instr_index;
    logic [2:0]       instr_opcode;
    logic [ChrW-1:0]  instr_char;
    logic [ChrW-1:0]  instr_low;
    logic [ChrW-1:0]  instr_high;
    logic [AddrW-1:0] instr_next_a;
    logic [AddrW-1:0] instr_next_b;

    modport source (output valid, mode, text_char, instr_index, instr_opcode, instr_char,
                    instr_low, instr_high, instr_next_a, instr_next_b, input ready);
    modport sink (input valid, mode, text_char, instr_index, instr_opcode, instr_char,
                  instr_low, instr_high, instr_next_a, instr_next_b, output ready);
endinterface

interface nrm_out_if import nrm_pkg::*;;
    logic             valid;
    logic             ready;
    logic [StatW-1:0] status;
    logic [CntW-1:0]  active_threads;

    modport source (output valid, status, active_threads, input ready);
    modport sink (input valid, status, active_threads, output ready);
endinterface

interface nrm_cfg_if import nrm_pkg::*;;
    logic             valid;
    logic             ready;
    logic [AddrW-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ----- rtl/nrm_front.sv -----
// nrm_front: accepts input transactions, classifies them and queues them
// depends on nrm_pkg and nrm_ifs
module nrm_front import nrm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    nrm_in_if.sink   i_in,
    output logic     o_q_valid,
    input  logic     i_q_ready,
    output t_qitem   o_q_item
);

    t_qitem     r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_qitem     w_item;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_item.chr          = i_in.text_char;
        w_item.idx          = i_in.instr_index;
        w_item.instr.op     = t_opcode'(i_in.instr_opcode);
        w_item.instr.chr    = i_in.instr_char;
        w_item.instr.lo     = i_in.instr_low;
        w_item.instr.hi     = i_in.instr_high;
        w_item.instr.next_a = i_in.instr_next_a;
        w_item.instr.next_b = i_in.instr_next_b;
        if (!i_in.mode) begin
            w_item.kind = K_LOAD;
        end else if (i_in.text_char == '0) begin
            w_item.kind = K_END;
        end else begin
            w_item.kind = K_CHAR;
        end
    end

    assign i_in.ready = (r_cnt != 2'd2);
    assign w_push     = i_in.valid && i_in.ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign w_pop      = o_q_valid && i_q_ready;
    assign o_q_item   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

// ----- rtl/nrm_back.sv -----
// nrm_back: program memory, thread-set engine with epsilon closure, result register
// depends on nrm_pkg and nrm_ifs
module nrm_back import nrm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    output logic       o_q_ready,
    input  t_qitem     i_q_item,
    nrm_cfg_if.sink    i_cfg,
    nrm_out_if.source  o_out
);

    typedef enum logic [1:0] {S_IDLE, S_CLOS, S_STEP, S_EMIT} t_state;
    typedef enum logic [1:0] {PH_IDLE, PH_RUN, PH_SKIP} t_phase;

    t_instr               r_mem [ProgDepth];
    t_instr               r_mem_q;

    t_state               r_state;
    t_phase               r_phase;
    logic [AddrW-1:0]     r_start;
    logic [ProgDepth-1:0] r_cur;    // thread set for the next character
    logic [CntW-1:0]      r_ccnt;
    logic [ProgDepth-1:0] r_vis;    // set under construction, doubles as visited mask
    logic [ProgDepth-1:0] r_pend;   // closure nodes still to expand
    logic [ProgDepth-1:0] r_rem;    // threads still to step
    logic [CntW-1:0]      r_cnt;
    logic                 r_matched;
    logic [ChrW-1:0]      r_chr;
    logic                 r_rd_valid;
    logic                 r_rd_thr;
    logic [AddrW-1:0]     r_rd_pc;
    logic [StatW-1:0]     r_res_status;
    logic [CntW-1:0]      r_res_cnt;
    logic                 r_out_valid;
    logic [StatW-1:0]     r_out_status;
    logic [CntW-1:0]      r_out_cnt;

    logic                 w_busy;
    logic                 w_t1v;
    logic                 w_t2v;
    logic [AddrW:0]       w_t1;
    logic [AddrW-1:0]     w_t2;
    logic [AddrW:0]       w_pc_inc;
    logic                 w_hit;
    logic                 w_new1;
    logic                 w_new2;
    logic [ProgDepth-1:0] w_add;
    logic                 w_iss;
    logic                 w_iss_thr;
    logic [AddrW-1:0]     w_iss_pc;
    logic [ProgDepth-1:0] w_iss_bit;
    logic                 w_done;
    logic [ProgDepth-1:0] w_vis_n;
    logic [CntW-1:0]      w_cnt_n;
    logic                 w_out_free;
    logic                 w_take;

    function automatic logic [AddrW-1:0] f_first(input logic [ProgDepth-1:0] m);
        logic [AddrW-1:0] r;
        r = '0;
        for (int k = ProgDepth - 1; k >= 0; k--) begin
            if (m[k]) r = AddrW'(k);
        end
        return r;
    endfunction

    assign i_cfg.ready          = 1'b1;
    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out_status;
    assign o_out.active_threads = r_out_cnt;
    assign o_q_ready            = (r_state == S_IDLE);
    assign w_take               = i_q_valid && o_q_ready;
    assign w_out_free           = !r_out_valid || o_out.ready;
    assign w_busy               = (r_state == S_CLOS) || (r_state == S_STEP);

    always_comb begin
        w_t1v    = 1'b0;
        w_t2v    = 1'b0;
        w_hit    = 1'b0;
        w_pc_inc = {1'b0, r_rd_pc} + (AddrW+1)'(1);
        w_t1     = w_pc_inc;
        w_t2     = r_mem_q.next_a;
        if (r_rd_valid) begin
            if (r_rd_thr) begin
                case (r_mem_q.op)
                    OP_CHAR:  w_t1v = (r_chr == r_mem_q.chr);
                    OP_RANGE: w_t1v = (r_chr != '0) && (r_chr >= r_mem_q.lo)
                                      && (r_chr <= r_mem_q.hi);
                    OP_ANY:   w_t1v = (r_chr != '0);
                    OP_MATCH: w_hit = 1'b1;
                    default:  w_t1v = 1'b0;
                endcase
            end else begin
                case (r_mem_q.op)
                    OP_JUMP: begin
                        w_t1v = 1'b1;
                        w_t1  = {1'b0, r_mem_q.next_a};
                    end
                    OP_SPLIT: begin
                        w_t1v = 1'b1;
                        w_t1  = {1'b0, r_mem_q.next_b};
                        w_t2v = 1'b1;
                    end
                    OP_SAVE: w_t1v = 1'b1;
                    default: w_t1v = 1'b0;
                endcase
            end
        end
        // the step past the last slot is dropped
        w_new1 = w_t1v && (w_t1 < (AddrW+1)'(ProgDepth)) && !r_vis[w_t1[AddrW-1:0]];
        w_new2 = w_t2v && !r_vis[w_t2] && !(w_new1 && (w_t2 == w_t1[AddrW-1:0]));
        w_add  = (w_new1 ? (ProgDepth'(1) << w_t1[AddrW-1:0]) : '0)
               | (w_new2 ? (ProgDepth'(1) << w_t2) : '0);

        w_iss     = 1'b0;
        w_iss_thr = 1'b0;
        w_iss_pc  = '0;
        if (w_busy) begin
            if (r_pend != '0) begin
                w_iss    = 1'b1;
                w_iss_pc = f_first(r_pend);
            end else if (r_rem != '0) begin
                w_iss     = 1'b1;
                w_iss_thr = 1'b1;
                w_iss_pc  = f_first(r_rem);
            end
        end
        w_iss_bit = w_iss ? (ProgDepth'(1) << w_iss_pc) : '0;
        w_done    = w_busy && !r_rd_valid && (r_pend == '0) && (r_rem == '0);
        w_vis_n   = r_vis | w_add;
        w_cnt_n   = r_cnt + CntW'(w_new1) + CntW'(w_new2);
    end

    always_ff @(posedge i_clk) begin
        if (w_take && (i_q_item.kind == K_LOAD)) begin
            r_mem[i_q_item.idx] <= i_q_item.instr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_iss) begin
            r_mem_q <= r_mem[w_iss_pc];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_IDLE;
            r_start     <= '0;
            r_ccnt      <= '0;
            r_cnt       <= '0;
            r_pend      <= '0;
            r_rem       <= '0;
            r_vis       <= '0;
            r_matched   <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) r_start <= i_cfg.data;
            r_out_valid <= (r_out_valid && !o_out.ready) || ((r_state == S_EMIT) && w_out_free);
            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_chr <= i_q_item.chr;
                        if (i_q_item.kind == K_LOAD) begin
                            r_res_status <= ST_LOADED;
                            r_res_cnt    <= (r_phase == PH_RUN) ? r_ccnt : '0;
                            r_state      <= S_EMIT;
                        end else if (r_phase == PH_SKIP) begin
                            if (i_q_item.kind == K_END) r_phase <= PH_IDLE;
                            r_res_status <= ST_SKIPPED;
                            r_res_cnt    <= '0;
                            r_state      <= S_EMIT;
                        end else if (r_phase == PH_IDLE) begin
                            r_vis   <= ProgDepth'(1) << r_start;
                            r_pend  <= ProgDepth'(1) << r_start;
                            r_cnt   <= CntW'(1);
                            r_rem   <= '0;
                            r_state <= S_CLOS;
                        end else begin
                            r_vis     <= '0;
                            r_pend    <= '0;
                            r_cnt     <= '0;
                            r_rem     <= r_cur;
                            r_matched <= 1'b0;
                            r_state   <= S_STEP;
                        end
                    end
                end
                S_CLOS, S_STEP: begin
                    r_rd_valid <= w_iss;
                    r_rd_thr   <= w_iss_thr;
                    r_rd_pc    <= w_iss_pc;
                    r_pend     <= (r_pend & ~(w_iss_thr ? '0 : w_iss_bit)) | w_add;
                    if (w_done && (r_state == S_CLOS)) begin
                        r_cur     <= r_vis;
                        r_ccnt    <= r_cnt;
                        r_rem     <= r_vis;
                        r_vis     <= '0;
                        r_cnt     <= '0;
                        r_matched <= 1'b0;
                        r_phase   <= PH_RUN;
                        r_state   <= S_STEP;
                    end else begin
                        r_vis <= w_vis_n;
                        r_cnt <= w_cnt_n;
                        r_rem <= r_rem & ~(w_iss_thr ? w_iss_bit : '0);
                        if (w_hit) r_matched <= 1'b1;
                        if (w_done) begin
                            if (r_matched || (r_chr == '0) || (r_cnt == '0)) begin
                                r_res_status <= r_matched ? ST_MATCHED : ST_NOMATCH;
                                r_res_cnt    <= '0;
                                r_ccnt       <= '0;
                                r_phase      <= (r_chr == '0) ? PH_IDLE : PH_SKIP;
                            end else begin
                                r_cur        <= r_vis;
                                r_ccnt       <= r_cnt;
                                r_res_status <= ST_PENDING;
                                r_res_cnt    <= r_cnt;
                            end
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_status <= r_res_status;
                        r_out_cnt    <= r_res_cnt;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(ProgDepth))
        else $error("thread count beyond program depth");

    a_pend_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend & ~r_vis) == '0)
        else $error("pending closure node not in thread set");

    a_rem_in_cur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> ((r_rem & ~r_cur) == '0))
        else $error("stepping a thread not in the current set");

    a_rd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> ((r_state == S_CLOS) || (r_state == S_STEP)))
        else $error("memory read outstanding outside the engine states");

endmodule

// ----- rtl/nfa_regex_thread_matcher.sv -----
// nfa_regex_thread_matcher: anchored regex matcher over a loaded NFA program
// a load result passes through the emit state and the output register once accepted; the time a
// character takes grows with N, the closure nodes plus threads stepped, since a node found by a
// memory read is issued only after that read returns; the first character of a string also
// walks the start closure; one item at a time
// reset (synchronous, active low) clears thread state and start index; program is kept
// depends on nrm_pkg, nrm_ifs, nrm_front and nrm_back
module nfa_regex_thread_matcher import nrm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    nrm_in_if.sink    i_in,
    nrm_cfg_if.sink   i_cfg,
    nrm_out_if.source o_out
);

    logic   w_q_valid;
    logic   w_q_ready;
    t_qitem w_q_item;

    nrm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (w_q_valid),
        .i_q_ready (w_q_ready),
        .o_q_item  (w_q_item)
    );

    nrm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_q_ready (w_q_ready),
        .i_q_item  (w_q_item),
        .i_cfg     (i_cfg),
        .o_out     (o_out)
    );

endmodule
